// File: hw/rtl/sphb_pkg.sv
package sphb_pkg;

  localparam logic [2:0] KIND_SYN  = 3'd1;
  localparam logic [2:0] KIND_NULL = 3'd2;
  localparam logic [2:0] KIND_ACK  = 3'd3;
  localparam logic [2:0] KIND_FIN  = 3'd4;
  localparam logic [2:0] KIND_XMAS = 3'd5;
  localparam logic [2:0] KIND_UDP  = 3'd6;

  localparam logic [15:0] PORT_BASE  = 16'd33000;
  localparam logic [15:0] TCP_WINDOW = 16'd5840;
  localparam logic [7:0]  IP_TTL     = 8'd64;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [15:0] IP_VER_IHL = 16'h4500;
  localparam logic [15:0] TCP_LEN    = 16'd20;
  localparam logic [15:0] UDP_LEN    = 16'd8;
  localparam logic [15:0] TCP_TOTAL  = 16'd40;
  localparam logic [15:0] UDP_TOTAL  = 16'd28;
  localparam logic [3:0]  TCP_DOFF   = 4'd5;

  localparam logic [5:0] FLAG_FIN = 6'h01;
  localparam logic [5:0] FLAG_SYN = 6'h02;
  localparam logic [5:0] FLAG_PSH = 6'h08;
  localparam logic [5:0] FLAG_ACK = 6'h10;
  localparam logic [5:0] FLAG_URG = 6'h20;

  localparam logic [4:0] TCP_LAST_IDX = 5'd19;
  localparam logic [4:0] UDP_LAST_IDX = 5'd13;

  localparam logic [2:0] CFG_SRC_ADDR = 3'd0;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] dport;
    logic [2:0]  kind;
    logic [15:0] ident;
    logic [31:0] seq;
  } probe_t;

  function automatic logic is_udp(input logic [2:0] kind);
    return kind == KIND_UDP;
  endfunction

  function automatic logic [5:0] tcp_flags(input logic [2:0] kind);
    logic [5:0] f;
    f = '0;
    unique case (kind)
      KIND_SYN:  f = FLAG_SYN;
      KIND_ACK:  f = FLAG_ACK;
      KIND_FIN:  f = FLAG_FIN;
      KIND_XMAS: f = FLAG_FIN | FLAG_PSH | FLAG_URG;
      default:   f = '0;
    endcase
    return f;
  endfunction

  function automatic logic tcp_ack(input logic [2:0] kind);
    return kind == KIND_ACK;
  endfunction

  // Fixed words of the IPv4 header that enter its checksum
  function automatic logic [15:0] ip_const(input logic [2:0] kind);
    logic [15:0] len;
    logic [7:0]  proto;
    len   = is_udp(kind) ? UDP_TOTAL : TCP_TOTAL;
    proto = is_udp(kind) ? PROTO_UDP : PROTO_TCP;
    return 16'(IP_VER_IHL + len + {IP_TTL, proto});
  endfunction

  // Fixed words of pseudo-header and transport header; cannot overflow 16 bits
  function automatic logic [15:0] tp_const(input logic [2:0] kind);
    logic [15:0] s;
    if (is_udp(kind)) begin
      s = 16'(16'(PROTO_UDP) + UDP_LEN + PORT_BASE + 16'(kind) + UDP_LEN);
    end else begin
      s = 16'(16'(PROTO_TCP) + TCP_LEN + PORT_BASE + 16'(kind) + 16'(tcp_ack(kind))
          + {TCP_DOFF, 6'd0, tcp_flags(kind)} + TCP_WINDOW);
    end
    return s;
  endfunction

endpackage

// File: hw/rtl/scan_probe_header_builder.sv
// Probe header builder. Each request word on in_ (destination address, port, ident,
// sequence number, kind in tuser) yields an IPv4+TCP header of 20 sixteen-bit words
// or, for the UDP kind, an IPv4+UDP header of 14 words, big-endian, tlast on the
// final word, both checksums filled in. The source address is the register at
// cfg_ offset 0. Requests pass a three-stage checksum pipeline (partial sums, first
// fold, final fold and invert) and then a word serialiser with an output register.
// The serialiser sends one word per cycle while out_tready is high, which sets the
// sustained rate of requests. Up to four requests are held in flight, so requests
// are taken back to back while earlier headers are still being sent, until the
// checksum stages are full.
module scan_probe_header_builder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] destination address, [47:32] destination port, [63:48] ip_ident,
  // [95:64] sequence_number
  input  logic [95:0]  in_tdata,
  // [2:0] scan_kind
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] header_word
  output logic [15:0]  out_tdata,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import sphb_pkg::*;

  logic [31:0] src_addr_r;

  logic        s1_v_r, s2_v_r, s3_v_r, frame_v_r, out_v_r;
  probe_t      s1_p_r, s2_p_r, s3_p_r, frame_p_r;
  logic [17:0] s1_addr_r;
  logic [16:0] s1_ip_r;
  logic [17:0] s1_tp_r;
  logic [16:0] s2_ip_r, s2_tp_r;
  logic [15:0] s3_ip_r, s3_tp_r, frame_ip_r, frame_tp_r;
  logic [4:0]  idx_r, idx_nxt;
  logic [15:0] out_data_r;
  logic        out_last_r;

  logic        s1_en, s2_en, s3_en, frame_ld, out_ld, emit, is_last, frame_done;
  probe_t      in_p;
  logic        in_udp;
  logic [15:0] seq_hi, seq_lo;
  logic [18:0] ip_sum, tp_sum;
  logic [16:0] ip_fold2, tp_fold2;
  logic [15:0] word;
  logic        fr_udp;

  // configuration
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == CFG_SRC_ADDR[0]) ? src_addr_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_addr_r <= '0;
    end else if (cfg_wr && cfg_paddr[2] == CFG_SRC_ADDR[0]) begin
      src_addr_r <= cfg_pwdata;
    end
  end

  // stall chain, back from the output register
  assign out_ld     = !out_v_r || out_tready;
  assign emit       = out_ld && frame_v_r;
  assign frame_done = emit && is_last;
  assign frame_ld   = s3_v_r && (!frame_v_r || frame_done);
  assign s3_en      = !s3_v_r || frame_ld;
  assign s2_en      = !s2_v_r || s3_en;
  assign s1_en      = !s1_v_r || s2_en;
  assign in_tready  = s1_en;

  // stage 1: partial sums
  always_comb begin
    in_p.src   = src_addr_r;
    in_p.dst   = in_tdata[31:0];
    in_p.dport = in_tdata[47:32];
    in_p.ident = in_tdata[63:48];
    in_p.seq   = in_tdata[95:64];
    in_p.kind  = in_tuser;
    in_udp     = is_udp(in_tuser);
    seq_hi     = in_udp ? 16'd0 : in_p.seq[31:16];
    seq_lo     = in_udp ? 16'd0 : in_p.seq[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_tvalid) begin
      s1_p_r    <= in_p;
      s1_addr_r <= 18'(in_p.src[31:16]) + 18'(in_p.src[15:0])
                 + 18'(in_p.dst[31:16]) + 18'(in_p.dst[15:0]);
      s1_ip_r   <= 17'(in_p.ident) + 17'(ip_const(in_tuser));
      s1_tp_r   <= 18'(in_p.dport) + 18'(seq_hi) + 18'(seq_lo)
                 + 18'(tp_const(in_tuser));
    end
  end

  // stage 2: total and first end-around fold
  assign ip_sum = 19'(s1_addr_r) + 19'(s1_ip_r);
  assign tp_sum = 19'(s1_addr_r) + 19'(s1_tp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_v_r) begin
      s2_p_r  <= s1_p_r;
      s2_ip_r <= 17'(ip_sum[15:0]) + 17'(ip_sum[18:16]);
      s2_tp_r <= 17'(tp_sum[15:0]) + 17'(tp_sum[18:16]);
    end
  end

  // stage 3: second fold and invert
  assign ip_fold2 = 17'(s2_ip_r[15:0]) + 17'(s2_ip_r[16]);
  assign tp_fold2 = 17'(s2_tp_r[15:0]) + 17'(s2_tp_r[16]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en && s2_v_r) begin
      s3_p_r  <= s2_p_r;
      s3_ip_r <= ~ip_fold2[15:0];
      s3_tp_r <= ~tp_fold2[15:0];
    end
  end

  // serialiser: hold one finished header and step through its words
  assign fr_udp  = is_udp(frame_p_r.kind);
  assign is_last = idx_r == (fr_udp ? UDP_LAST_IDX : TCP_LAST_IDX);

  always_comb begin
    word = '0;
    unique case (idx_r)
      5'd0:    word = IP_VER_IHL;
      5'd1:    word = fr_udp ? UDP_TOTAL : TCP_TOTAL;
      5'd2:    word = frame_p_r.ident;
      5'd3:    word = '0;
      5'd4:    word = {IP_TTL, fr_udp ? PROTO_UDP : PROTO_TCP};
      5'd5:    word = frame_ip_r;
      5'd6:    word = frame_p_r.src[31:16];
      5'd7:    word = frame_p_r.src[15:0];
      5'd8:    word = frame_p_r.dst[31:16];
      5'd9:    word = frame_p_r.dst[15:0];
      5'd10:   word = 16'(PORT_BASE + 16'(frame_p_r.kind));
      5'd11:   word = frame_p_r.dport;
      5'd12:   word = fr_udp ? UDP_LEN : frame_p_r.seq[31:16];
      5'd13:   word = fr_udp ? frame_tp_r : frame_p_r.seq[15:0];
      5'd14:   word = '0;
      5'd15:   word = 16'(tcp_ack(frame_p_r.kind));
      5'd16:   word = {TCP_DOFF, 6'd0, tcp_flags(frame_p_r.kind)};
      5'd17:   word = TCP_WINDOW;
      5'd18:   word = frame_tp_r;
      default: word = '0;
    endcase
  end

  assign idx_nxt = frame_done ? 5'd0 : (emit ? 5'(idx_r + 5'd1) : idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_v_r <= 1'b0;
      idx_r     <= '0;
      out_v_r   <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (frame_ld) begin
        frame_v_r <= 1'b1;
      end else if (frame_done) begin
        frame_v_r <= 1'b0;
      end
      if (out_ld) begin
        out_v_r <= frame_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_ld) begin
      frame_p_r  <= s3_p_r;
      frame_ip_r <= s3_ip_r;
      frame_tp_r <= s3_tp_r;
    end
    if (emit) begin
      out_data_r <= word;
      out_last_r <= is_last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// File: hw/rtl/sphb_checker.sv
module sphb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_pready
);
  import sphb_pkg::*;

  logic start_r;

  // mark the next word as the first of a header
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b1;
    end else if (out_tvalid && out_tready) begin
      start_r <= out_tlast;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result word changed");

  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && start_r |-> out_tdata == IP_VER_IHL && !out_tlast)
    else $error("header does not open with version and IHL");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("configuration port not ready");

endmodule

bind scan_probe_header_builder sphb_checker u_sphb_checker (.*);

// File: dv/scan_probe_header_builder_test.sv
module scan_probe_header_builder_test;
  import sphb_pkg::*;

  typedef logic [15:0] word_t;

  // one probe request; pinned rows carry both checksums typed in by hand
  typedef struct {
    logic [31:0] dst;
    logic [15:0] dport;
    logic [2:0]  kind;
    logic [15:0] ident;
    logic [31:0] seq;
    bit          pinned;
    word_t       ip_sum;
    word_t       tp_sum;
  } probe_row_t;

  typedef struct {
    word_t word;
    logic  last;
  } header_word_t;

  // kinds outside the defined set, built as flagless TCP
  localparam logic [2:0] KIND_RSVD_LO = 3'd0;
  localparam logic [2:0] KIND_RSVD_HI = 3'd7;

  localparam logic [2:0] SRC_ADDR_OFS = 3'(CFG_SRC_ADDR * 4);
  localparam logic [2:0] SPARE_OFS    = 3'd4;

  localparam int IP_SUM_IDX     = 5;
  localparam int UDP_SUM_IDX    = 13;
  localparam int TCP_SUM_IDX    = 18;
  localparam int MAX_WAIT       = 10;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASES         = 4;
  localparam int PHASE_PROBES   = 65;
  localparam int DIRECTED_ROWS  = 15;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;
  logic [2:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [15:0]  out_tdata;
  logic         out_tlast;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  logic [31:0]  src_address;
  header_word_t header_words [$];
  probe_row_t   directed_rows [DIRECTED_ROWS];

  int mismatches;
  int words_checked;
  int probes_sent;
  int udp_sent;
  int odd_kind_sent;
  int settings_used;
  int in_calm;
  int out_calm;
  int idle_cycles;

  scan_probe_header_builder DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // random gap of up to MAX_WAIT, with occasional runs of back-to-back words
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(5, 25);
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 9))
      0: return 16'h0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic word_t ones_fold(input logic [31:0] acc);
    logic [31:0] s;
    s = {16'd0, acc[31:16]} + {16'd0, acc[15:0]};
    s = s + (s >> 16);
    return ~s[15:0];
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  // work out the datagram header for one request and queue its words
  task automatic expect_header(input probe_row_t r);
    word_t       w [20];
    logic [31:0] acc;
    logic [5:0]  flags;
    logic        ack;
    logic        udp;
    logic [7:0]  proto;
    word_t       tlen;
    int          total;
    int          sum_idx;
    header_word_t hw;
    udp     = (r.kind == KIND_UDP);
    total   = udp ? 14 : 20;
    proto   = udp ? PROTO_UDP : PROTO_TCP;
    tlen    = udp ? UDP_LEN : TCP_LEN;
    sum_idx = udp ? UDP_SUM_IDX : TCP_SUM_IDX;
    for (int i = 0; i < 20; i++) w[i] = '0;

    w[0] = IP_VER_IHL;
    w[1] = udp ? UDP_TOTAL : TCP_TOTAL;
    w[2] = r.ident;
    w[4] = {IP_TTL, proto};
    w[6] = src_address[31:16];
    w[7] = src_address[15:0];
    w[8] = r.dst[31:16];
    w[9] = r.dst[15:0];
    acc = '0;
    for (int i = 0; i < 10; i++) acc += {16'd0, w[i]};
    w[IP_SUM_IDX] = ones_fold(acc);

    w[10] = PORT_BASE + 16'(r.kind);
    w[11] = r.dport;
    if (udp) begin
      w[12] = UDP_LEN;
    end else begin
      flags = '0;
      ack   = 1'b0;
      case (r.kind)
        KIND_SYN:  flags = FLAG_SYN;
        KIND_ACK: begin
          flags = FLAG_ACK;
          ack   = 1'b1;
        end
        KIND_FIN:  flags = FLAG_FIN;
        KIND_XMAS: flags = FLAG_FIN | FLAG_PSH | FLAG_URG;
        default:   flags = '0;
      endcase
      w[12] = r.seq[31:16];
      w[13] = r.seq[15:0];
      w[15] = {15'd0, ack};
      w[16] = {TCP_DOFF, 6'd0, flags};
      w[17] = TCP_WINDOW;
    end

    // pseudo-header first, then the transport header with its checksum still zero
    acc = {16'd0, src_address[31:16]} + {16'd0, src_address[15:0]}
        + {16'd0, r.dst[31:16]} + {16'd0, r.dst[15:0]} + {24'd0, proto} + {16'd0, tlen};
    for (int i = 10; i < total; i++) acc += {16'd0, w[i]};
    w[sum_idx] = ones_fold(acc);

    if (r.pinned) begin
      w[IP_SUM_IDX] = r.ip_sum;
      w[sum_idx]    = r.tp_sum;
    end

    for (int i = 0; i < total; i++) begin
      hw.word = w[i];
      hw.last = (i == total - 1);
      header_words.push_back(hw);
    end
  endtask

  task automatic send_probe(input probe_row_t r);
    int gap;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r.seq, r.ident, r.dport, r.dst};
    in_tuser  <= r.kind;
    do @(posedge clk); while (!in_tready);
    expect_header(r);
    probes_sent++;
    if (r.kind == KIND_UDP) udp_sent++;
    if (r.kind == KIND_RSVD_LO || r.kind == KIND_RSVD_HI) odd_kind_sent++;
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == SRC_ADDR_OFS) src_address = data;
    @(posedge clk);
  endtask

  task automatic cfg_check_source();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= SRC_ADDR_OFS;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== src_address)
      note_mismatch($sformatf("source address read: expected %h, got %h",
                              src_address, cfg_prdata));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // hold the sender and let every queued word arrive
  task automatic drain();
    in_tvalid <= 1'b0;
    while (header_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side
  initial begin
    int           stall;
    header_word_t want;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait(out_calm);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (header_words.size() == 0) begin
        note_mismatch($sformatf("word %h tlast %b with nothing expected",
                                out_tdata, out_tlast));
      end else begin
        want = header_words.pop_front();
        words_checked++;
        if (out_tdata !== want.word)
          note_mismatch($sformatf("header word: expected %h, got %h",
                                  want.word, out_tdata));
        if (out_tlast !== want.last)
          note_mismatch($sformatf("tlast on word %h: expected %b, got %b",
                                  want.word, want.last, out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("stalled with %0d words outstanding", header_words.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    probe_row_t r;
    logic [31:0] setting;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    src_address = '0;
    mismatches    = 0;
    words_checked = 0;
    probes_sent   = 0;
    udp_sent      = 0;
    odd_kind_sent = 0;
    settings_used = 1;
    in_calm       = 0;
    out_calm      = 0;
    idle_cycles   = 0;

    // the last two rows are chosen so that both checksums fold to zero with source 0
    directed_rows = '{
      '{32'h0000_0000, 16'h0000, KIND_SYN,     16'h0000, 32'h0000_0000, 1'b0, 16'h0, 16'h0},
      '{32'hFFFF_FFFF, 16'hFFFF, KIND_NULL,    16'hFFFF, 32'hFFFF_FFFF, 1'b0, 16'h0, 16'h0},
      '{32'hC0A8_0101, 16'd80,   KIND_ACK,     16'h1234, 32'hDEAD_BEEF, 1'b0, 16'h0, 16'h0},
      '{32'h0A00_0001, 16'd443,  KIND_FIN,     16'hFFFE, 32'h0000_0001, 1'b0, 16'h0, 16'h0},
      '{32'h5555_5555, 16'hAAAA, KIND_XMAS,    16'h5555, 32'hAAAA_AAAA, 1'b0, 16'h0, 16'h0},
      '{32'hAAAA_AAAA, 16'h5555, KIND_XMAS,    16'hAAAA, 32'h5555_5555, 1'b0, 16'h0, 16'h0},
      '{32'hFFFF_FFFF, 16'hFFFF, KIND_UDP,     16'hFFFF, 32'hFFFF_FFFF, 1'b0, 16'h0, 16'h0},
      '{32'h0000_0000, 16'h0000, KIND_UDP,     16'h0000, 32'h0000_0000, 1'b0, 16'h0, 16'h0},
      '{32'h0808_0808, 16'd53,   KIND_UDP,     16'h0001, 32'h1234_5678, 1'b0, 16'h0, 16'h0},
      '{32'h7F00_0001, 16'd22,   KIND_RSVD_LO, 16'h0100, 32'h8000_0000, 1'b0, 16'h0, 16'h0},
      '{32'hFFFF_FFFF, 16'hFFFF, KIND_RSVD_HI, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 16'h0, 16'h0},
      '{32'h0000_0000, 16'h0000, KIND_ACK,     16'h0000, 32'hFFFF_FFFF, 1'b0, 16'h0, 16'h0},
      '{32'h8000_0000, 16'h8000, KIND_NULL,    16'h8000, 32'h0000_0000, 1'b0, 16'h0, 16'h0},
      '{32'h0000_0000, 16'h7EF0, KIND_UDP,     16'h7AD2, 32'h0000_0000, 1'b1, 16'h0, 16'h0},
      '{32'h0000_0000, 16'h182A, KIND_SYN,     16'h7AD1, 32'h0000_0000, 1'b1, 16'h0, 16'h0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_check_source();
    foreach (directed_rows[i]) send_probe(directed_rows[i]);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: setting = 32'hFFFF_FFFF;
        2: setting = 32'h0000_0000;
        default: setting = $urandom;
      endcase
      // the spare offset holds no register; the write must leave the source alone
      cfg_write(SPARE_OFS, $urandom);
      cfg_check_source();
      cfg_write(SRC_ADDR_OFS, setting);
      cfg_check_source();
      settings_used++;
      for (int k = 0; k < PHASE_PROBES; k++) begin
        r.dst   = pick32();
        r.dport = pick16();
        r.ident = pick16();
        r.seq   = pick32();
        if ($urandom_range(0, 19) < 2)
          r.kind = $urandom_range(0, 1) ? KIND_RSVD_HI : KIND_RSVD_LO;
        else
          r.kind = 3'($urandom_range(KIND_SYN, KIND_UDP));
        r.pinned = 1'b0;
        r.ip_sum = '0;
        r.tp_sum = '0;
        send_probe(r);
      end
    end

    drain();
    $display("summary: %0d probes (%0d udp, %0d of undefined kind) under %0d source addresses",
             probes_sent, udp_sent, odd_kind_sent, settings_used);
    $display("summary: %0d header words checked, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0 && header_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/sphb_pkg.sv
hw/rtl/scan_probe_header_builder.sv
hw/rtl/sphb_checker.sv
dv/scan_probe_header_builder_test.sv
